@@ src/dqe_pkg.sv @@
package dqe_pkg;

  // protocol limits
  localparam int MAX_LABEL       = 63;
  localparam int MAX_NAME_OCTETS = 255;
  localparam int HDR_LEN         = 12;
  localparam int TRL_LEN         = 5;
  localparam int BUF_OVERHEAD    = 18;
  localparam int BUF_SIZE_RESET  = 512;
  localparam int LBL_W           = 6;

  localparam logic [7:0] DOT_CHAR   = 8'h2E;
  localparam logic [7:0] QTYPE_A    = 8'h01;
  localparam logic [7:0] QTYPE_AAAA = 8'h1C;
  localparam logic [7:0] QCLASS_IN  = 8'h01;
  localparam logic [7:0] HDR_ONE    = 8'h01;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_LABEL  = 2'd1,
    ST_NAME   = 2'd2,
    ST_BUFFER = 2'd3
  } st_t;

  // byte source select
  typedef enum logic [1:0] {
    SRC_HDR = 2'd0,
    SRC_LEN = 2'd1,
    SRC_CHR = 2'd2,
    SRC_TRL = 2'd3
  } src_t;

  // sections one request produces
  typedef struct packed {
    logic hdr;
    logic lbl;
    logic trl;
    st_t  err;
  } plan_t;

  // controller to datapath
  typedef struct packed {
    logic             accept;
    logic             push;
    logic             fin;
    src_t             src;
    logic [LBL_W-1:0] idx;
    logic             err_push;
    st_t              err_code;
    logic [LBL_W-1:0] rd_addr;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    plan_t            plan;
    logic [LBL_W-1:0] emit_len;
    logic             space;
  } sts_t;

endpackage

@@ src/dqe_datapath.sv @@
module dqe_datapath
  import dqe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic [15:0] in_tdata,
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  output logic [1:0]  out_tuser,
  output logic        out_tlast,
  input  cmd_t        cmd,
  output sts_t        sts
);

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_ACTIVE = 3'b010,
    PH_DROP   = 3'b100
  } ph_t;

  function automatic logic [7:0] hdr_byte(input logic [3:0] i);
    logic [7:0] b;
    b = 8'h00;
    if (i == 4'd2 || i == 4'd5) b = HDR_ONE;
    return b;
  endfunction

  function automatic logic [7:0] trl_byte(input logic [3:0] i, input logic v6);
    logic [7:0] b;
    b = 8'h00;
    if (i == 4'd2) b = v6 ? QTYPE_AAAA : QTYPE_A;
    if (i == 4'd4) b = QCLASS_IN;
    return b;
  endfunction

  logic [15:0]      bsize_r;
  ph_t              phase_r, phase_nxt;
  logic [LBL_W-1:0] len_r, len_nxt;
  logic [8:0]       oct_r, oct_nxt;
  logic [15:0]      nc_r, nc_nxt;
  logic             pdot_r, pdot_nxt;
  logic             v6_r;
  logic [LBL_W-1:0] emit_len_r;
  logic [7:0]       mem [0:MAX_LABEL-1];
  logic [7:0]       rd_data_r;

  logic             pend_v_r;
  logic [7:0]       pend_b_r;
  logic             out_v_r;
  logic [7:0]       o_b0_r, o_b1_r;
  logic [1:0]       o_cnt_r;
  st_t              o_st_r;
  logic             o_last_r;

  logic [7:0]       ch;
  logic             v6_in, is_end, first, drop;
  logic [LBL_W-1:0] len_cur;
  logic [8:0]       oct_cur;
  logic [15:0]      nc_cur, nc_inc, nc_chk;
  logic             pd_cur, buf_short, over, full, store;
  logic [9:0]       total;
  plan_t            plan;
  logic [7:0]       byte_v;

  assign ch     = in_tdata[7:0];
  assign v6_in  = in_tdata[8];
  assign is_end = in_tuser;
  assign first  = (phase_r == PH_IDLE);
  assign drop   = (phase_r == PH_DROP);

  // name state as seen by this request
  assign len_cur = first ? '0 : len_r;
  assign oct_cur = first ? '0 : oct_r;
  assign nc_cur  = first ? '0 : nc_r;
  assign pd_cur  = first ? 1'b0 : pdot_r;
  assign nc_inc  = (nc_cur == 16'hFFFF) ? nc_cur : nc_cur + 16'd1;
  assign nc_chk  = is_end ? nc_cur : nc_inc;

  // size checks
  assign buf_short = ({1'b0, nc_chk} + 17'(BUF_OVERHEAD)) > {1'b0, bsize_r};
  assign total     = {1'b0, oct_cur} + 10'd1 + {4'b0, len_cur};
  assign over      = total > 10'(MAX_NAME_OCTETS);
  assign full      = len_cur >= LBL_W'(MAX_LABEL);

  // decide what this request produces and its next name state
  always_comb begin
    plan      = '{hdr: 1'b0, lbl: 1'b0, trl: 1'b0, err: ST_OK};
    phase_nxt = phase_r;
    len_nxt   = len_cur;
    oct_nxt   = oct_cur;
    nc_nxt    = nc_cur;
    pdot_nxt  = pd_cur;
    store     = 1'b0;
    if (drop) begin
      if (is_end) phase_nxt = PH_IDLE;
    end else begin
      plan.hdr  = first;
      phase_nxt = PH_ACTIVE;
      if (!is_end) begin
        nc_nxt = nc_inc;
        priority if (buf_short) begin
          plan.err  = ST_BUFFER;
          phase_nxt = PH_DROP;
        end else if (ch == DOT_CHAR) begin
          if (over) begin
            plan.err  = ST_NAME;
            phase_nxt = PH_DROP;
          end else begin
            plan.lbl = 1'b1;
            oct_nxt  = total[8:0];
            len_nxt  = '0;
            pdot_nxt = 1'b1;
          end
        end else if (full) begin
          plan.err  = ST_LABEL;
          phase_nxt = PH_DROP;
        end else begin
          store    = 1'b1;
          len_nxt  = len_cur + LBL_W'(1);
          pdot_nxt = 1'b0;
        end
      end else begin
        phase_nxt = PH_IDLE;
        priority if (buf_short) begin
          plan.err = ST_BUFFER;
        end else if (!pd_cur && over) begin
          plan.err = ST_NAME;
        end else begin
          plan.lbl = !pd_cur;
          plan.trl = 1'b1;
        end
      end
    end
  end

  // configuration and name state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bsize_r <= 16'(BUF_SIZE_RESET);
      phase_r <= PH_IDLE;
      len_r   <= '0;
      oct_r   <= '0;
      nc_r    <= '0;
      pdot_r  <= 1'b0;
      v6_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) bsize_r <= cfg_wr_data;
      if (cmd.accept) begin
        phase_r <= phase_nxt;
        len_r   <= len_nxt;
        oct_r   <= oct_nxt;
        nc_r    <= nc_nxt;
        pdot_r  <= pdot_nxt;
        if (first) v6_r <= v6_in;
      end
    end
  end

  // label length captured for emission
  always_ff @(posedge clk) begin
    if (cmd.accept) emit_len_r <= len_cur;
  end

  // label store
  always_ff @(posedge clk) begin
    if (cmd.accept && store) mem[len_cur] <= ch;
    rd_data_r <= mem[cmd.rd_addr];
  end

  // byte source
  always_comb begin
    unique case (cmd.src)
      SRC_HDR: byte_v = hdr_byte(cmd.idx[3:0]);
      SRC_LEN: byte_v = {2'b00, emit_len_r};
      SRC_CHR: byte_v = rd_data_r;
      SRC_TRL: byte_v = trl_byte(cmd.idx[3:0], v6_r);
      default: byte_v = 8'h00;
    endcase
  end

  // pair packer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (cmd.err_push) begin
        out_v_r  <= 1'b1;
        o_b0_r   <= 8'h00;
        o_b1_r   <= 8'h00;
        o_cnt_r  <= 2'd0;
        o_st_r   <= cmd.err_code;
        o_last_r <= 1'b1;
      end else if (cmd.push && pend_v_r) begin
        out_v_r  <= 1'b1;
        o_b0_r   <= pend_b_r;
        o_b1_r   <= byte_v;
        o_cnt_r  <= 2'd2;
        o_st_r   <= ST_OK;
        o_last_r <= cmd.fin;
        pend_v_r <= 1'b0;
      end else if (cmd.push && cmd.fin) begin
        out_v_r  <= 1'b1;
        o_b0_r   <= byte_v;
        o_b1_r   <= 8'h00;
        o_cnt_r  <= 2'd1;
        o_st_r   <= ST_OK;
        o_last_r <= 1'b1;
      end else begin
        if (out_tready) out_v_r <= 1'b0;
        if (cmd.push) begin
          pend_b_r <= byte_v;
          pend_v_r <= 1'b1;
        end
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'b0, o_cnt_r, o_b1_r, o_b0_r};
  assign out_tuser  = o_st_r;
  assign out_tlast  = o_last_r;

  assign sts.plan     = plan;
  assign sts.emit_len = emit_len_r;
  assign sts.space    = !out_v_r || out_tready;

endmodule

@@ src/dqe_ctrl.sv @@
module dqe_ctrl
  import dqe_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_HDR  = 6'b000010,
    S_LEN  = 6'b000100,
    S_CHR  = 6'b001000,
    S_TRL  = 6'b010000,
    S_ERR  = 6'b100000
  } state_t;

  state_t           state_r, state_nxt;
  logic [LBL_W-1:0] cnt_r, cnt_nxt;
  logic             lbl_r, trl_r;
  st_t              err_r;
  logic             ok, sec_last, step;
  logic [LBL_W-1:0] cnt_inc;
  state_t           after_hdr, after_lbl, after_trl, from_idle;

  assign in_tready = (state_r == S_IDLE);
  assign ok        = (err_r == ST_OK);
  assign cnt_inc   = cnt_r + LBL_W'(1);
  assign step      = sts.space;

  // section ordering
  assign after_trl = ok ? S_IDLE : S_ERR;
  assign after_lbl = trl_r ? S_TRL : after_trl;
  assign after_hdr = lbl_r ? S_LEN : after_lbl;
  always_comb begin
    priority if (sts.plan.hdr)            from_idle = S_HDR;
    else if (sts.plan.lbl)                from_idle = S_LEN;
    else if (sts.plan.trl)                from_idle = S_TRL;
    else if (sts.plan.err != ST_OK)       from_idle = S_ERR;
    else                                  from_idle = S_IDLE;
  end

  // sequencing and commands
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    sec_last     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.push     = 1'b0;
    cmd.fin      = 1'b0;
    cmd.src      = SRC_HDR;
    cmd.idx      = cnt_r;
    cmd.err_push = 1'b0;
    cmd.err_code = err_r;
    cmd.rd_addr  = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.accept = in_tvalid;
        if (in_tvalid) begin
          state_nxt = from_idle;
          cnt_nxt   = '0;
        end
      end
      S_HDR: begin
        sec_last = (cnt_r == LBL_W'(HDR_LEN - 1));
        cmd.src  = SRC_HDR;
        cmd.push = step;
        cmd.fin  = sec_last && !lbl_r && !trl_r && ok;
        if (step) begin
          cnt_nxt = sec_last ? '0 : cnt_inc;
          if (sec_last) state_nxt = after_hdr;
        end
      end
      S_LEN: begin
        cmd.src     = SRC_LEN;
        cmd.rd_addr = '0;
        cmd.push    = step;
        cmd.fin     = (sts.emit_len == '0) && !trl_r && ok;
        if (step) begin
          cnt_nxt   = '0;
          state_nxt = (sts.emit_len != '0) ? S_CHR : after_lbl;
        end
      end
      S_CHR: begin
        sec_last = (cnt_inc == sts.emit_len);
        cmd.src  = SRC_CHR;
        cmd.push = step;
        cmd.fin  = sec_last && !trl_r && ok;
        if (step && !sec_last) cmd.rd_addr = cnt_inc;
        if (step) begin
          cnt_nxt = sec_last ? '0 : cnt_inc;
          if (sec_last) state_nxt = after_lbl;
        end
      end
      S_TRL: begin
        sec_last = (cnt_r == LBL_W'(TRL_LEN - 1));
        cmd.src  = SRC_TRL;
        cmd.push = step;
        cmd.fin  = sec_last && ok;
        if (step) begin
          cnt_nxt = sec_last ? '0 : cnt_inc;
          if (sec_last) state_nxt = after_trl;
        end
      end
      S_ERR: begin
        cmd.err_push = step;
        if (step) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and latched plan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      lbl_r   <= 1'b0;
      trl_r   <= 1'b0;
      err_r   <= ST_OK;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cmd.accept) begin
        lbl_r <= sts.plan.lbl;
        trl_r <= sts.plan.trl;
        err_r <= sts.plan.err;
      end
    end
  end

endmodule

@@ src/dns_query_encoder_top.sv @@
// channel | dir | tdata (low bit up)                      | tuser         | tlast
// in_     | in  | char_byte[7:0], want_ipv6[8], pad[15:9]  | req_type      | -
// out_    | out | byte_first[7:0], byte_second[15:8],      | status[1:0]   | is_last
//         |     | byte_count[17:16], pad[23:18]            |               |
// cfg_    | in  | cfg_wr_data = buffer_size, written when cfg_wr_en is high
//
// a character request that only buffers is accepted without leaving S_IDLE; a request
// that emits bytes runs the sequencer through them (12 header, 1 + label length,
// 5 trailer), then through an error result if there is one; the controller's byte
// sequencer feeds one byte a cycle to the pair packer unless out_tready stalls it.
// in_tready is high only while the sequencer is idle; a held result does not block it.
// out_tready low while a result is held stalls the sequencer in place; the label store
// has no clearing pass.
// reset is synchronous on rst_n; buffer_size resets to 512.
module dns_query_encoder_top
  import dqe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // char_byte[7:0], want_ipv6[8]
  input  logic        in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // byte_first[7:0], byte_second[15:8], byte_count[17:16]
  output logic [1:0]  out_tuser,  // status
  output logic        out_tlast
);

  cmd_t cmd;
  sts_t sts;

  // byte sequencer
  dqe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // name state, label store and packer
  dqe_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

@@ src/dqe_checker.sv @@
module dqe_checker
  import dqe_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("stalled result changed");

  // error result is bare and ends the run
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tlast && out_tdata == 24'h0)
    else $error("error result malformed");

  // a result with no bytes is an error
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[17:16] == 2'd0 |-> out_tuser != ST_OK)
    else $error("empty ok result");

  // single byte only closes a run, second byte zero
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[17:16] == 2'd1 |-> out_tlast && out_tdata[15:8] == 8'h0)
    else $error("single byte result malformed");

  // byte count in range
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[17:16] != 2'd3 && out_tdata[23:18] == 6'd0)
    else $error("bad byte count");

endmodule

bind dns_query_encoder_top dqe_checker u_dqe_checker (.*);
